// ----- design/tbf_pkg.sv -----
// Package for the T=1 block framer: channel payload structs, PCB constants
// and the burst record passed from the framing core to the output buffer.
// No dependencies.
`default_nettype none

package tbf_pkg;

   localparam logic       OP_BEGIN = 1'b0;
   localparam logic       OP_INFO  = 1'b1;

   localparam logic [1:0] KIND_I = 2'd0;
   localparam logic [1:0] KIND_R = 2'd1;
   localparam logic [1:0] KIND_S = 2'd2;

   localparam logic [7:0] PCB_NS_BIT   = 8'h40;
   localparam logic [7:0] PCB_MORE_BIT = 8'h20;
   localparam logic [7:0] PCB_NR_BIT   = 8'h10;
   localparam logic [7:0] PCB_I_BASE   = 8'h00;

   localparam int unsigned BURST_MAX = 4;

   typedef struct packed {
      logic       op;
      logic [1:0] block_kind;
      logic [7:0] pcb_type;
      logic       seq_bit;
      logic       more_data;
      logic [7:0] info_len;
      logic [7:0] info_byte;
   } tbf_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       block_end;
   } tbf_rsp_type;

   typedef struct packed {
      logic [BURST_MAX-1:0][7:0] bytes;
      logic [2:0]                count;
      logic                      closes;
   } tbf_burst_type;

endpackage

`default_nettype wire

// ----- design/tbf_frame_core.sv -----
// Framing core: holds the node address, LRC, remaining length and open flag,
// and turns one accepted transfer into a burst of up to four bytes.
// Depends on tbf_pkg.
`default_nettype none

module tbf_frame_core
   import tbf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_wr_en,
   input  wire logic [7:0]    csr_wr_data,
   input  wire logic          accept,
   input  wire tbf_req_type   req,
   output tbf_burst_type      burst
);

   logic [7:0] nad_ff;
   logic [7:0] lrc_ff, lrc_in;
   logic [7:0] left_ff, left_in;
   logic       open_ff, open_in;
   logic [7:0] pcb;
   logic [7:0] len;
   logic [7:0] sum;

   always_comb begin
      pcb     = req.pcb_type;
      len     = req.info_len;
      sum     = '0;
      burst   = '0;
      lrc_in  = lrc_ff;
      left_in = left_ff;
      open_in = open_ff;
      if (req.op == OP_BEGIN) begin
         unique case (req.block_kind)
            KIND_I: begin
               pcb = PCB_I_BASE | (req.seq_bit ? PCB_NS_BIT : 8'h00)
                     | (req.more_data ? PCB_MORE_BIT : 8'h00);
            end
            KIND_R: begin
               pcb = req.pcb_type | (req.seq_bit ? PCB_NR_BIT : 8'h00);
               len = 8'h00;
            end
            default: begin
               pcb = req.pcb_type;
            end
         endcase
         sum = nad_ff ^ pcb ^ len;
         burst.bytes[0] = nad_ff;
         burst.bytes[1] = pcb;
         burst.bytes[2] = len;
         burst.bytes[3] = sum;
         lrc_in = sum;
         if (len == 8'h00) begin
            burst.count  = 3'd4;
            burst.closes = 1'b1;
            open_in      = 1'b0;
            left_in      = 8'h00;
         end else begin
            burst.count = 3'd3;
            open_in     = 1'b1;
            left_in     = len;
         end
      end else if (open_ff) begin
         sum = lrc_ff ^ req.info_byte;
         burst.bytes[0] = req.info_byte;
         burst.bytes[1] = sum;
         lrc_in  = sum;
         left_in = left_ff - 8'd1;
         if (left_ff == 8'd1) begin
            burst.count  = 3'd2;
            burst.closes = 1'b1;
            open_in      = 1'b0;
         end else begin
            burst.count = 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nad_ff  <= '0;
         lrc_ff  <= '0;
         left_ff <= '0;
         open_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            nad_ff <= csr_wr_data;
         end
         if (accept) begin
            lrc_ff  <= lrc_in;
            left_ff <= left_in;
            open_ff <= open_in;
         end
      end
   end

`ifndef ASSERT_OFF
   a_open_has_bytes: assert property (@(posedge clock) disable iff (reset)
      open_ff |-> left_ff != 8'h00)
      else $error("block open with no bytes left");
   a_closed_no_bytes: assert property (@(posedge clock) disable iff (reset)
      !open_ff |-> left_ff == 8'h00)
      else $error("closed block with bytes left");
   a_begin_burst: assert property (@(posedge clock) disable iff (reset)
      (accept && req.op == OP_BEGIN) |-> (burst.count == 3'd3 || burst.count == 3'd4))
      else $error("begin transfer without header burst");
`endif

endmodule

`default_nettype wire

// ----- design/tbf_burst_out.sv -----
// Output buffer: holds one burst of up to four bytes and presents them one
// per cycle while rsp_ready is high, flagging the LRC byte. Uses tbf_pkg.
`default_nettype none

module tbf_burst_out
   import tbf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          load,
   input  wire tbf_burst_type burst,
   output logic               can_load,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output tbf_rsp_type        rsp_data
);

   logic [BURST_MAX-1:0][7:0] bytes_ff, bytes_in;
   logic [2:0]                cnt_ff, cnt_in;
   logic                      closes_ff, closes_in;
   logic                      pop;

   assign rsp_valid          = cnt_ff != 3'd0;
   assign pop                = rsp_valid && rsp_ready;
   assign can_load           = (cnt_ff == 3'd0) || (cnt_ff == 3'd1 && rsp_ready);
   assign rsp_data.out_byte  = bytes_ff[0];
   assign rsp_data.block_end = closes_ff && cnt_ff == 3'd1;

   always_comb begin
      bytes_in  = bytes_ff;
      cnt_in    = cnt_ff;
      closes_in = closes_ff;
      if (load) begin
         bytes_in  = burst.bytes;
         cnt_in    = burst.count;
         closes_in = burst.closes;
      end else if (pop) begin
         for (int i = 0; i < BURST_MAX - 1; i++) begin
            bytes_in[i] = bytes_ff[i+1];
         end
         bytes_in[BURST_MAX-1] = 8'h00;
         cnt_in = cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      if (reset) begin
         cnt_ff    <= '0;
         closes_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         closes_ff <= closes_in;
      end
   end

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'd4)
      else $error("burst count out of range");
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> (cnt_ff == 3'd0 || (cnt_ff == 3'd1 && rsp_ready)))
      else $error("burst loaded over pending bytes");
   a_pop_decrements: assert property (@(posedge clock) disable iff (reset)
      (pop && !load) |=> cnt_ff == $past(cnt_ff) - 3'd1)
      else $error("byte count did not follow transfer");
`endif

endmodule

`default_nettype wire

// ----- design/t1_block_framer.sv -----
// Top level of the T=1 block framer: request, response and CSR ports.
// Instantiates tbf_frame_core and tbf_burst_out; depends on tbf_pkg.
//
//   channel  direction  handshake             payload
//   req_     in         req_valid/req_ready   tbf_req_type
//   rsp_     out        rsp_valid/rsp_ready   tbf_rsp_type
//   csr_     in         csr_wr_en             csr_wr_data (node address)
//
// Each request is framed combinationally into a burst that drains one byte
// per cycle while rsp_ready is high: an info transfer gives one byte (two
// when it closes the block), a begin three or four; the buffer sets the rate.
// Reset is synchronous and clears the framing state and the buffer.
// A stalled response holds the buffer; a new request is taken in the cycle
// its last byte transfers.
`default_nettype none

module t1_block_framer
   import tbf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire tbf_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output tbf_rsp_type      rsp_data,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data
);

   tbf_burst_type burst;
   logic          accept;
   logic          can_load;

   assign req_ready = can_load;
   assign accept    = req_valid && req_ready;

   tbf_frame_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .req         (req_data),
      .burst       (burst)
   );

   tbf_burst_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .burst     (burst),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
